@@ design/stable_priority_request_queue_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the stable priority request queue
// Concurrent checks, active only in simulation builds.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_REQUEST_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_REQUEST_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SPQ_ASSERT_ALWAYS(label, prop, msg)
`define SPQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ design/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the priority request queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Request type codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_POPPED    = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  localparam int OCC_W = 5;

  typedef struct packed {
    logic [7:0]  id;
    logic [3:0]  priority_lvl;
    logic [31:0] stamp;
  } spq_entry_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  req_id;
    logic [3:0]  req_priority;
    logic [31:0] req_stamp;
  } spq_req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       out_id;
    logic [3:0]       out_priority;
    logic [31:0]      out_stamp;
    logic [OCC_W-1:0] occupancy;
  } spq_rsp_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // insert new entry in sorted place
    logic del;  // remove first matching entry, close the gap
    logic pop;  // match is head-only instead of by id
  } spq_ctrl_t;

endpackage

@@ design/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: compares, shifts right on insert, left on
// removal.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  spq_ctrl_t  ctrl,
  input  spq_entry_t new_entry,
  input  logic       is_head,
  input  spq_entry_t left_entry,
  input  logic       left_valid,
  input  logic       left_after,
  input  spq_entry_t right_entry,
  input  logic       right_valid,
  input  logic       found_in,
  output spq_entry_t entry,
  output logic       valid,
  output logic       after,
  output logic       found_out,
  output spq_entry_t hit_entry
);

  spq_entry_t entry_r, entry_nxt;
  logic       valid_r, valid_nxt;
  logic       match;

  // New entry sorts ahead of this slot (ties on priority and stamp go behind).
  assign after = !valid_r
              || (new_entry.priority_lvl < entry_r.priority_lvl)
              || ((new_entry.priority_lvl == entry_r.priority_lvl)
                  && (new_entry.stamp < entry_r.stamp));

  assign match     = ctrl.del && valid_r && (ctrl.pop ? is_head : (entry_r.id == new_entry.id));
  assign found_out = found_in || match;
  assign hit_entry = (match && !found_in) ? entry_r : '0;

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctrl.ins && after) begin
      if (left_after) begin
        entry_nxt = left_entry;
        valid_nxt = left_valid;
      end else begin
        entry_nxt = new_entry;
        valid_nxt = 1'b1;
      end
    end else if (ctrl.del && found_out) begin
      entry_nxt = right_entry;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule

@@ design/stable_priority_request_queue.sv @@
// ----------------------------------------------------------------------------
// stable_priority_request_queue
// Sorted priority queue of requests built from a row of compare/shift cells.
// ----------------------------------------------------------------------------
//
//  Port group | Dir | Handshake          | Carries
//  -----------+-----+--------------------+----------------------------------
//  in_*       | in  | in_valid/in_stall  | spq_req_t: type, id, prio, stamp
//  out_*      | out | out_valid/out_stall| spq_rsp_t: status, entry, count
//
//  Each operation completes inside the cell row at the transfer; the result
//  appears in the output register in the cycle after the transfer.
//  Throughput is one request per cycle while in_stall is low.
//  in_stall rises only while a result sits in the output register and
//  out_stall holds it there.
//  Reset (rst_n low, synchronous) empties the queue and the output register.
//
module stable_priority_request_queue import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  spq_req_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output spq_rsp_t out_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic       in_fire;
  logic       full;
  spq_ctrl_t  ctrl;
  spq_entry_t new_entry;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  logic [CNT_W-1:0] count_r, count_nxt;
  assign full = (count_r == CNT_FULL);

  assign ctrl.ins = in_fire && (in_data.req_type == REQ_INSERT) && !full;
  assign ctrl.del = in_fire && ((in_data.req_type == REQ_POP)
                             || (in_data.req_type == REQ_REMOVE));
  assign ctrl.pop = (in_data.req_type == REQ_POP);

  assign new_entry.id           = in_data.req_id;
  assign new_entry.priority_lvl = in_data.req_priority;
  assign new_entry.stamp        = in_data.req_stamp;

  // --------------------------------------------------------------------------
  // Cell row: slot 0 is the head. Inserts shift the tail right, removals
  // close the gap by shifting left. found_chain marks slots at or past the
  // first hit.
  // --------------------------------------------------------------------------
  spq_entry_t             cell_entry [QUEUE_DEPTH];
  spq_entry_t             cell_hit   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [QUEUE_DEPTH-1:0] cell_after;
  logic [QUEUE_DEPTH:0]   found_chain;

  assign found_chain[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_entry_t l_entry, r_entry;
    logic       l_valid, l_after, r_valid;

    if (i == 0) begin : g_head
      assign l_entry = new_entry;
      assign l_valid = 1'b1;
      assign l_after = 1'b0;
    end else begin : g_mid
      assign l_entry = cell_entry[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_after = cell_after[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_entry = new_entry;
      assign r_valid = 1'b0;
    end else begin : g_body
      assign r_entry = cell_entry[i+1];
      assign r_valid = cell_valid[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_entry  (new_entry),
      .is_head    (i == 0),
      .left_entry (l_entry),
      .left_valid (l_valid),
      .left_after (l_after),
      .right_entry(r_entry),
      .right_valid(r_valid),
      .found_in   (found_chain[i]),
      .entry      (cell_entry[i]),
      .valid      (cell_valid[i]),
      .after      (cell_after[i]),
      .found_out  (found_chain[i+1]),
      .hit_entry  (cell_hit[i])
    );
  end

  // At most one cell presents a nonzero hit entry.
  spq_entry_t hit;
  logic       found_any;

  assign found_any = found_chain[QUEUE_DEPTH];

  always_comb begin
    hit = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit = hit | cell_hit[i];
    end
  end

  // --------------------------------------------------------------------------
  // Occupancy
  // --------------------------------------------------------------------------
  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.del && found_any) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result build and output register
  // --------------------------------------------------------------------------
  spq_rsp_t rsp;

  always_comb begin
    case (in_data.req_type)
      REQ_INSERT: rsp.status = full ? ST_FULL : ST_INSERTED;
      REQ_POP:    rsp.status = found_any ? ST_POPPED : ST_EMPTY;
      REQ_REMOVE: rsp.status = found_any ? ST_REMOVED : ST_NOT_FOUND;
      default:    rsp.status = ST_NOT_FOUND;
    endcase
    rsp.out_id       = hit.id;
    rsp.out_priority = hit.priority_lvl;
    rsp.out_stamp    = hit.stamp;
    rsp.occupancy    = OCC_W'(count_nxt);
  end

  spq_rsp_t out_data_r;

  // Register is free whenever in_stall is low: either empty or being drained.
  assign out_valid_nxt = in_stall ? out_valid_r : in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "stable_priority_request_queue_assert.svh"

  `SPQ_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_FULL, "occupancy above depth")
  `SPQ_ASSERT_ALWAYS(a_valid_count, $countones(cell_valid) == int'(count_r), "valid count")
  `SPQ_ASSERT_NEXT(a_insert_grows, ctrl.ins, count_r == $past(count_r) + CNT_W'(1), "count stuck")
  `SPQ_ASSERT_NEXT(a_result_follows, in_fire, out_valid_r, "accepted request produced no result")

endmodule
